// ===== rtl/assert_macros.svh =====
// Assertion macros used by the parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Concurrent implication checked at every clock edge outside reset.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/sysl_pkg.sv =====
// Types and constants of the syslog header parser.
package sysl_pkg;

  localparam int TEXT_CAP_DEF = 604;
  localparam int FIFO_DEPTH   = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CTRL_LIM = 8'h20;
  localparam logic [7:0] ESC_FLIP = 8'h40;
  localparam int         HDR_LEN  = 16;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_TEXT   = 2'd2,
    PH_DONE   = 2'd3
  } sysl_phase_t;

  typedef enum logic [2:0] {
    SEC_TS   = 3'd0,
    SEC_SEP  = 3'd1,
    SEC_HOST = 3'd2,
    SEC_TAG  = 3'd3,
    SEC_BODY = 3'd4,
    SEC_SEP2 = 3'd5
  } sysl_sec_t;

  // One classified input item queued for the output side.
  typedef struct packed {
    logic [7:0] ch;      // raw byte
    logic       valid;   // item carries text
    logic       esc;     // control byte, emit as escape pair
    logic       lt15a;   // first char position below 15
    logic       lt15b;   // second char position below 15
    logic       last;    // last item of the line
    logic       hdr_ok;  // header verdict at line end
    logic [9:0] pri;     // priority at line end
  } sysl_entry_t;

endpackage

// ===== rtl/syslog_header_parser_top.sv =====
// Syslog header parser: takes one log line a byte at a time and sends out
// the escaped text, each byte tagged with its header section. Control bytes
// below 0x20 leave as a caret pair, so one input byte gives at most two
// results. The front end takes a byte every cycle while its four-entry queue
// has room; the output side sends one result per cycle while the queue holds
// an entry and the receiver is ready. The last result of a line (tlast)
// carries the header verdict, facility and severity; a line with no text
// gives a single result with tuser bit 0 clear.
module syslog_header_parser_top import sysl_pkg::*; #(
  parameter int TEXT_CAP = TEXT_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [8] header_ok,
                                      // [15:9] facility, [18:16] severity, rest 0
  output logic [3:0]  m_axis_tuser,   // [0] byte_valid, [3:1] section
  output logic        m_axis_tlast    // line_end
);

`include "assert_macros.svh"

  sysl_entry_t push_entry, head;
  logic        push, push_ready, pop, head_valid;
  logic [7:0]  out_byte;
  logic        byte_valid, line_end, header_ok;
  logic [2:0]  section, severity;
  logic [6:0]  facility;

  sysl_front #(.TEXT_CAP(TEXT_CAP)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  sysl_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sysl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .section    (section),
    .line_end   (line_end),
    .header_ok  (header_ok),
    .facility   (facility),
    .severity   (severity)
  );

  assign m_axis_tdata = {5'd0, severity, facility, header_ok, out_byte};
  assign m_axis_tuser = {section, byte_valid};
  assign m_axis_tlast = line_end;

  `ASSERT_IMP(a_empty_is_end, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
  `ASSERT_IMP(a_summary_zero, clk, rst, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[18:8] == 11'd0)
  `ASSERT_IMP(a_section_range, clk, rst, m_axis_tvalid, m_axis_tuser[3:1] <= 3'd4)
  `ASSERT_NEXT(a_pop_fills_out, clk, rst, pop, m_axis_tvalid)

endmodule

// ===== rtl/sysl_front.sv =====
// Front end: prefix parsing, priority, text count, header check, queue push.
module sysl_front import sysl_pkg::*; #(
  parameter int TEXT_CAP = TEXT_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        push,
  output sysl_entry_t push_entry,
  input  logic        push_ready
);

  localparam int CW = $clog2(TEXT_CAP + 2);

  sysl_phase_t   phase, phase_next;
  logic [9:0]    pri, pri_next;
  logic [CW-1:0] count, count_next;
  logic          match, match_next;

  logic       acc, is_digit, take, stop, emit, esc, fail;
  logic [3:0] digit;

  function automatic logic bad_char(input logic [7:0] ch, input logic [CW-1:0] pos);
    logic r;
    r = 1'b0;
    if (pos == CW'(3) || pos == CW'(6) || pos == CW'(15)) r = (ch != CH_SPACE);
    else if (pos == CW'(9) || pos == CW'(12)) r = (ch != CH_COLON);
    return r;
  endfunction

  assign in_ready = push_ready;
  assign acc      = in_valid && in_ready;
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign digit    = 4'(in_byte - CH_ZERO);
  assign esc      = in_byte < CTRL_LIM;
  assign stop     = (in_byte == CH_NUL) || (count >= CW'(TEXT_CAP));
  assign take     = (phase == PH_START && in_byte != CH_LT) ||
                    (phase == PH_DIGITS && !is_digit && in_byte != CH_GT) ||
                    (phase == PH_TEXT);
  assign emit     = take && !stop;

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_START: begin
        if (in_byte == CH_LT) phase_next = PH_DIGITS;
        else phase_next = stop ? PH_DONE : PH_TEXT;
      end
      PH_DIGITS: begin
        if (is_digit) phase_next = PH_DIGITS;
        else if (in_byte == CH_GT) phase_next = PH_TEXT;
        else phase_next = stop ? PH_DONE : PH_TEXT;
      end
      PH_TEXT: phase_next = stop ? PH_DONE : PH_TEXT;
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_START;
    endcase
  end

  // datapath
  always_comb begin
    pri_next = pri;
    if (phase == PH_START && in_byte == CH_LT) pri_next = '0;
    else if (phase == PH_DIGITS && is_digit)
      pri_next = 10'((pri << 3) + (pri << 1) + {6'd0, digit});

    fail = 1'b0;
    if (emit) begin
      if (esc) fail = bad_char(CH_CARET, count) || bad_char(in_byte ^ ESC_FLIP, count + 1'b1);
      else fail = bad_char(in_byte, count);
    end
    match_next = match && !fail;
    count_next = emit ? (esc ? count + CW'(2) : count + CW'(1)) : count;

    push_entry.ch     = in_byte;
    push_entry.valid  = emit;
    push_entry.esc    = emit && esc;
    push_entry.lt15a  = count < CW'(15);
    push_entry.lt15b  = count < CW'(14);
    push_entry.last   = in_last;
    push_entry.hdr_ok = match_next && (count_next >= CW'(HDR_LEN));
    push_entry.pri    = pri_next;
  end

  assign push = acc && (emit || in_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      pri   <= '0;
      count <= '0;
      match <= 1'b1;
    end else if (acc) begin
      if (in_last) begin
        // restart for the next line
        phase <= PH_START;
        pri   <= '0;
        count <= '0;
        match <= 1'b1;
      end else begin
        phase <= phase_next;
        pri   <= pri_next;
        count <= count_next;
        match <= match_next;
      end
    end
  end

endmodule

// ===== rtl/sysl_fifo.sv =====
// Short queue between front end and output side.
module sysl_fifo import sysl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  sysl_entry_t push_entry,
  output logic        push_ready,
  input  logic        pop,
  output logic        head_valid,
  output sysl_entry_t head
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  sysl_entry_t   mem [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] fill;
  logic          do_push, do_pop;

  assign push_ready = fill != NW'(FIFO_DEPTH);
  assign head_valid = fill != '0;
  assign head       = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule

// ===== rtl/sysl_back.sv =====
// Output side: escape expansion, section tagging, output register.
module sysl_back import sysl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  sysl_entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic [2:0]  section,
  output logic        line_end,
  output logic        header_ok,
  output logic [6:0]  facility,
  output logic [2:0]  severity
);

  sysl_sec_t  fsec, fsec_next, sec;
  logic       half, load, is_end, lt15, sp;
  logic [7:0] ch;

  assign load   = head_valid && (!out_valid || out_ready);
  assign ch     = head.esc ? (half ? (head.ch ^ ESC_FLIP) : CH_CARET) : head.ch;
  assign lt15   = half ? head.lt15b : head.lt15a;
  assign is_end = head.last && (!head.esc || half);
  assign pop    = load && (!head.esc || half);
  assign sp     = ch == CH_SPACE;

  // section of the current char and the tracker's next value
  always_comb begin
    fsec_next = fsec;
    sec       = SEC_TS;
    if (!lt15) begin
      unique case (fsec)
        SEC_TS: begin
          fsec_next = SEC_SEP;
          sec       = SEC_SEP;
        end
        SEC_SEP: begin
          if (!sp) fsec_next = SEC_HOST;
          sec = sp ? SEC_SEP : SEC_HOST;
        end
        SEC_HOST: begin
          if (sp) fsec_next = SEC_SEP2;
          sec = sp ? SEC_SEP : SEC_HOST;
        end
        SEC_SEP2: begin
          if (sp) sec = SEC_SEP;
          else begin
            fsec_next = (ch == CH_COLON) ? SEC_BODY : SEC_TAG;
            sec       = fsec_next;
          end
        end
        SEC_TAG: begin
          if (ch == CH_COLON) fsec_next = SEC_BODY;
          sec = fsec_next;
        end
        default: begin
          fsec_next = SEC_BODY;
          sec       = SEC_BODY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
      fsec      <= SEC_TS;
    end else if (load) begin
      out_valid <= 1'b1;
      half      <= head.esc && !half;
      if (is_end) fsec <= SEC_TS;
      else if (head.valid) fsec <= fsec_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= head.valid ? ch : 8'h00;
      byte_valid <= head.valid;
      section    <= head.valid ? 3'(sec) : 3'(SEC_TS);
      line_end   <= is_end;
      header_ok  <= is_end && head.hdr_ok;
      facility   <= is_end ? head.pri[9:3] : 7'd0;
      severity   <= is_end ? head.pri[2:0] : 3'd0;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the syslog header parser: random log lines, scoreboard check.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sysl_pkg::*;

  localparam int TEXT_CAP       = TEXT_CAP_DEF;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 32;

  localparam string DIGITS     = "0123456789";
  localparam string LETTERS    = "ADFJMNOSabcegilnoprtuvy";
  localparam string HOST_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789.-";
  localparam string TAG_CHARS  = "abcdefghijklmnopqrstuvwxyz0123456789[]";

  // One parsed text character as it should leave the block.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_text;
    logic [2:0] sect;
    logic       eol;
    logic       hdr_ok;
    logic [6:0] facility;
    logic [2:0] severity;
  } parsed_char_t;

  class syslog_scoreboard;
    sysl_phase_t  phase;
    logic [9:0]   pri;
    int unsigned  text_cnt;
    bit           hdr_match;
    sysl_sec_t    cur_sec;
    int unsigned  cap;
    parsed_char_t expected_q[$];
    int           mismatches;

    function new(int unsigned cap_val);
      cap = cap_val;
      mismatches = 0;
      restart_line();
    endfunction

    function void restart_line();
      phase     = PH_START;
      pri       = '0;
      text_cnt  = 0;
      hdr_match = 1'b1;
      cur_sec   = SEC_TS;
    endfunction

    function sysl_sec_t section_of(logic [7:0] ch, int unsigned pos);
      bit sp;
      sp = (ch == CH_SPACE);
      if (pos < HDR_LEN - 1) return SEC_TS;
      case (cur_sec)
        SEC_TS: begin
          cur_sec = SEC_SEP;
          return SEC_SEP;
        end
        SEC_SEP: begin
          if (!sp) cur_sec = SEC_HOST;
          return cur_sec;
        end
        SEC_HOST: begin
          if (!sp) return SEC_HOST;
          cur_sec = SEC_SEP2;
          return SEC_SEP;
        end
        SEC_SEP2: begin
          if (sp) return SEC_SEP;
          cur_sec = (ch == CH_COLON) ? SEC_BODY : SEC_TAG;
          return cur_sec;
        end
        SEC_TAG: begin
          if (ch == CH_COLON) cur_sec = SEC_BODY;
          return cur_sec;
        end
        default: begin
          cur_sec = SEC_BODY;
          return SEC_BODY;
        end
      endcase
    endfunction

    function void push_char(logic [7:0] ch);
      parsed_char_t r;
      int unsigned  pos;
      pos = text_cnt;
      if (pos == 3 || pos == 6 || pos == 15) begin
        if (ch != CH_SPACE) hdr_match = 1'b0;
      end else if (pos == 9 || pos == 12) begin
        if (ch != CH_COLON) hdr_match = 1'b0;
      end
      r          = '0;
      r.ch       = ch;
      r.has_text = 1'b1;
      r.sect     = section_of(ch, pos);
      expected_q.push_back(r);
      text_cnt = pos + 1;
    endfunction

    // Returns how many characters the byte adds to the text.
    function int absorb(logic [7:0] b);
      if (b == CH_NUL || text_cnt >= cap) begin
        phase = PH_DONE;
        return 0;
      end
      phase = PH_TEXT;
      if (b < CTRL_LIM) begin
        push_char(CH_CARET);
        push_char(b ^ ESC_FLIP);
        return 2;
      end
      push_char(b);
      return 1;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      int           n;
      parsed_char_t r;
      n = 0;
      case (phase)
        PH_START: begin
          if (b == CH_LT) begin
            phase = PH_DIGITS;
            pri   = '0;
          end else begin
            n = absorb(b);
          end
        end
        PH_DIGITS: begin
          if (b >= CH_ZERO && b <= CH_NINE) pri = pri * 10'd10 + {2'b00, b - CH_ZERO};
          else if (b == CH_GT) phase = PH_TEXT;
          else n = absorb(b);
        end
        PH_TEXT: n = absorb(b);
        default: ;
      endcase
      if (last) begin
        // Summary rides on the last character, or on an empty result.
        r = (n == 0) ? parsed_char_t'('0) : expected_q.pop_back();
        r.eol      = 1'b1;
        r.hdr_ok   = hdr_match && (text_cnt >= HDR_LEN);
        r.facility = pri[9:3];
        r.severity = pri[2:0];
        expected_q.push_back(r);
        restart_line();
      end
    endfunction

    function void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_result(logic [23:0] td, logic [3:0] tu, logic tl);
      parsed_char_t e;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing pending: tdata 0x%0h tuser 0x%0h tlast %0b",
               td, tu, tl);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      check_field("out_byte", 32'(e.ch), 32'(td[7:0]));
      check_field("byte_valid", 32'(e.has_text), 32'(tu[0]));
      check_field("section", 32'(e.sect), 32'(tu[3:1]));
      check_field("line_end", 32'(e.eol), 32'(tl));
      check_field("header_ok", 32'(e.hdr_ok), 32'(td[8]));
      check_field("facility", 32'(e.facility), 32'(td[15:9]));
      check_field("severity", 32'(e.severity), 32'(td[18:16]));
      check_field("tdata padding", 32'd0, 32'(td[23:19]));
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_byte
  logic        s_axis_tlast  = 1'b0; // in_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [7:0] out_byte, [8] header_ok,
                                     // [15:9] facility, [18:16] severity
  logic [3:0]  m_axis_tuser;         // [0] byte_valid, [3:1] section
  logic        m_axis_tlast;         // line_end

  syslog_scoreboard sb;
  logic [7:0]       line_buf[$];
  int               items_sent = 0;
  bit               tx_steady  = 1'b0;
  int               idle_cycles = 0;

  syslog_header_parser_top #(.TEXT_CAP(TEXT_CAP)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample both sides in one place so input notes always precede result checks.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side: random stalls, with stretches of steady ready.
  initial begin
    int stall;
    bit rx_steady;
    rx_steady = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_steady = ~rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_line();
    tx_steady = ($urandom_range(0, 4) == 0);
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  // Hold the input side until every pending result has arrived.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // Priority prefix, timestamp header, hostname, tag and body with random content.
  function automatic void add_wellformed();
    int r;
    if ($urandom_range(0, 9) < 8) begin
      line_buf.push_back(CH_LT);
      repeat ($urandom_range(1, 4)) line_buf.push_back(pick(DIGITS));
      if ($urandom_range(0, 9) != 0) line_buf.push_back(CH_GT);
    end
    for (int p = 0; p < HDR_LEN; p++) begin
      if (p == 3 || p == 6 || p == 15) line_buf.push_back(CH_SPACE);
      else if (p == 9 || p == 12) line_buf.push_back(CH_COLON);
      else if (p < 3) line_buf.push_back(pick(LETTERS));
      else line_buf.push_back(pick(DIGITS));
    end
    repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
    repeat ($urandom_range(1, 8)) line_buf.push_back(pick(HOST_CHARS));
    repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
    repeat ($urandom_range(0, 6)) line_buf.push_back(pick(TAG_CHARS));
    line_buf.push_back(CH_COLON);
    repeat ($urandom_range(0, 24)) begin
      r = $urandom_range(0, 99);
      if (r < 8) line_buf.push_back(8'($urandom_range(1, 31)));
      else if (r < 11) line_buf.push_back(8'($urandom_range(128, 255)));
      else if (r == 11) line_buf.push_back(CH_NUL);
      else if (r < 20) line_buf.push_back(CH_SPACE);
      else line_buf.push_back(8'($urandom_range(33, 126)));
    end
  endfunction

  initial begin
    int         kind;
    int         cnt;
    int         idx;
    bit         paused_mid;
    logic [7:0] b;
    sb = new(TEXT_CAP);
    paused_mid = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Priority that wraps, then a consumed closing bracket.
    add_text("<99999>a");
    send_line();
    // Lone opening bracket: next byte is text.
    add_text("<x");
    send_line();
    // Line that is only a zero byte.
    line_buf.push_back(CH_NUL);
    send_line();
    // Escapes, top byte, zero byte with a dropped byte after it.
    line_buf = '{8'h01, 8'hFF, 8'h1F, CH_NUL, 8'h41};
    send_line();
    // Digits ended by a control byte.
    line_buf = '{CH_LT, 8'h37, 8'h0A};
    send_line();
    add_text("<");
    send_line();
    add_text("<12>");
    send_line();
    line_buf.push_back(CH_SPACE);
    send_line();
    wait_drained();

    // Fill the text up to the cap; a control byte at the edge overshoots by one.
    add_text("<13>");
    cnt = 0;
    while (cnt < TEXT_CAP) begin
      if (cnt == TEXT_CAP - 1 || $urandom_range(0, 15) == 0) b = 8'($urandom_range(1, 31));
      else b = 8'($urandom_range(32, 255));
      line_buf.push_back(b);
      cnt += (b < CTRL_LIM) ? 2 : 1;
    end
    repeat (3) line_buf.push_back(8'($urandom_range(0, 255)));
    send_line();

    while (items_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        add_wellformed();
      end else if (kind < 85) begin
        // Broken line: corrupt or cut a well-formed one.
        add_wellformed();
        idx = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 2))
          0: line_buf[idx] = 8'($urandom_range(0, 255));
          1: while (line_buf.size() > idx + 1) void'(line_buf.pop_back());
          default: line_buf[idx] = 8'($urandom_range(0, 31));
        endcase
      end else begin
        if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_LT);
        repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
      send_line();
      if (!paused_mid && items_sent > (TEXT_CAP + RANDOM_ITEMS) / 2) begin
        wait_drained();
        paused_mid = 1'b1;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
